/* rtl/core/rtk_pkg.sv */
// rtk_pkg: shared types, constants and syllable table of the romaji to kana transliterator
`timescale 1ns / 1ps
package rtk_pkg;

	localparam int QUEUE_DEPTH = 4;
	localparam logic [15:0] CP_SMALL_TSU = 16'h3063;
	localparam logic [7:0] UTF8_LEAD = 8'hE3;

	typedef struct packed {
		logic [7:0] in_char;
		logic       char_valid;
		logic       end_of_string;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic        byte_valid;
		logic        string_done;
		logic        overflow;
		logic [15:0] total_length;
		logic        run_last;
	} out_item_t;

	typedef enum logic [1:0] {
		OP_KANA1,
		OP_KANA2,
		OP_PASS,
		OP_STATUS
	} op_kind_t;

	typedef struct packed {
		op_kind_t    kind;
		logic [15:0] cp1;
		logic [15:0] cp2;
		logic [7:0]  data;
		logic        ovf;
		logic [15:0] total;
		logic        last;
	} op_t;

	typedef enum logic [1:0] {
		FS_IDLE,
		FS_STEP,
		FS_FLUSH
	} front_state_t;

	typedef struct packed {
		logic        hit;
		logic [15:0] cp1;
		logic [15:0] cp2;
	} syl_t;

	function automatic logic [7:0] fold(input logic [7:0] c);
		return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
	endfunction

	function automatic syl_t mk(input logic [15:0] a, input logic [15:0] b);
		syl_t r;
		r.hit = 1'b1;
		r.cp1 = a;
		r.cp2 = b;
		return r;
	endfunction

	function automatic syl_t syl3(input logic [23:0] k);
		syl_t r;
		r = '0;
		case (k)
			"kya": r = mk(16'h304D, 16'h3083);
			"kyu": r = mk(16'h304D, 16'h3085);
			"kyo": r = mk(16'h304D, 16'h3087);
			"sha": r = mk(16'h3057, 16'h3083);
			"shu": r = mk(16'h3057, 16'h3085);
			"sho": r = mk(16'h3057, 16'h3087);
			"sya": r = mk(16'h3057, 16'h3083);
			"syu": r = mk(16'h3057, 16'h3085);
			"cha": r = mk(16'h3061, 16'h3083);
			"chu": r = mk(16'h3061, 16'h3085);
			"cho": r = mk(16'h3061, 16'h3087);
			"tya": r = mk(16'h3061, 16'h3083);
			"tyu": r = mk(16'h3061, 16'h3085);
			"nya": r = mk(16'h306B, 16'h3083);
			"nyu": r = mk(16'h306B, 16'h3085);
			"nyo": r = mk(16'h306B, 16'h3087);
			"hya": r = mk(16'h3072, 16'h3083);
			"hyu": r = mk(16'h3072, 16'h3085);
			"hyo": r = mk(16'h3072, 16'h3087);
			"mya": r = mk(16'h307F, 16'h3083);
			"myu": r = mk(16'h307F, 16'h3085);
			"myo": r = mk(16'h307F, 16'h3087);
			"rya": r = mk(16'h308A, 16'h3083);
			"ryu": r = mk(16'h308A, 16'h3085);
			"ryo": r = mk(16'h308A, 16'h3087);
			"gya": r = mk(16'h304E, 16'h3083);
			"gyu": r = mk(16'h304E, 16'h3085);
			"gyo": r = mk(16'h304E, 16'h3087);
			"jya": r = mk(16'h3058, 16'h3083);
			"jyu": r = mk(16'h3058, 16'h3085);
			"jyo": r = mk(16'h3058, 16'h3087);
			"zya": r = mk(16'h3058, 16'h3083);
			"zyu": r = mk(16'h3058, 16'h3085);
			"bya": r = mk(16'h3073, 16'h3083);
			"byu": r = mk(16'h3073, 16'h3085);
			"byo": r = mk(16'h3073, 16'h3087);
			"pya": r = mk(16'h3074, 16'h3083);
			"pyu": r = mk(16'h3074, 16'h3085);
			"pyo": r = mk(16'h3074, 16'h3087);
			"shi": r = mk(16'h3057, 16'h0000);
			"chi": r = mk(16'h3061, 16'h0000);
			"tsu": r = mk(16'h3064, 16'h0000);
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic syl_t syl2(input logic [15:0] k);
		syl_t r;
		r = '0;
		case (k)
			"ja": r = mk(16'h3058, 16'h3083);
			"ju": r = mk(16'h3058, 16'h3085);
			"jo": r = mk(16'h3058, 16'h3087);
			"ka": r = mk(16'h304B, 16'h0000);
			"ki": r = mk(16'h304D, 16'h0000);
			"ku": r = mk(16'h304F, 16'h0000);
			"ke": r = mk(16'h3051, 16'h0000);
			"ko": r = mk(16'h3053, 16'h0000);
			"sa": r = mk(16'h3055, 16'h0000);
			"si": r = mk(16'h3057, 16'h0000);
			"su": r = mk(16'h3059, 16'h0000);
			"se": r = mk(16'h305B, 16'h0000);
			"so": r = mk(16'h305D, 16'h0000);
			"ta": r = mk(16'h305F, 16'h0000);
			"ti": r = mk(16'h3061, 16'h0000);
			"tu": r = mk(16'h3064, 16'h0000);
			"te": r = mk(16'h3066, 16'h0000);
			"to": r = mk(16'h3068, 16'h0000);
			"na": r = mk(16'h306A, 16'h0000);
			"ni": r = mk(16'h306B, 16'h0000);
			"nu": r = mk(16'h306C, 16'h0000);
			"ne": r = mk(16'h306D, 16'h0000);
			"no": r = mk(16'h306E, 16'h0000);
			"ha": r = mk(16'h306F, 16'h0000);
			"hi": r = mk(16'h3072, 16'h0000);
			"fu": r = mk(16'h3075, 16'h0000);
			"hu": r = mk(16'h3075, 16'h0000);
			"he": r = mk(16'h3078, 16'h0000);
			"ho": r = mk(16'h307B, 16'h0000);
			"ma": r = mk(16'h307E, 16'h0000);
			"mi": r = mk(16'h307F, 16'h0000);
			"mu": r = mk(16'h3080, 16'h0000);
			"me": r = mk(16'h3081, 16'h0000);
			"mo": r = mk(16'h3082, 16'h0000);
			"ya": r = mk(16'h3084, 16'h0000);
			"yu": r = mk(16'h3086, 16'h0000);
			"yo": r = mk(16'h3088, 16'h0000);
			"ra": r = mk(16'h3089, 16'h0000);
			"ri": r = mk(16'h308A, 16'h0000);
			"ru": r = mk(16'h308B, 16'h0000);
			"re": r = mk(16'h308C, 16'h0000);
			"ro": r = mk(16'h308D, 16'h0000);
			"wa": r = mk(16'h308F, 16'h0000);
			"wo": r = mk(16'h3092, 16'h0000);
			"ga": r = mk(16'h304C, 16'h0000);
			"gi": r = mk(16'h304E, 16'h0000);
			"gu": r = mk(16'h3050, 16'h0000);
			"ge": r = mk(16'h3052, 16'h0000);
			"go": r = mk(16'h3054, 16'h0000);
			"za": r = mk(16'h3056, 16'h0000);
			"zi": r = mk(16'h3058, 16'h0000);
			"ji": r = mk(16'h3058, 16'h0000);
			"zu": r = mk(16'h305A, 16'h0000);
			"ze": r = mk(16'h305C, 16'h0000);
			"zo": r = mk(16'h305E, 16'h0000);
			"da": r = mk(16'h3060, 16'h0000);
			"di": r = mk(16'h3062, 16'h0000);
			"du": r = mk(16'h3065, 16'h0000);
			"de": r = mk(16'h3067, 16'h0000);
			"do": r = mk(16'h3069, 16'h0000);
			"ba": r = mk(16'h3070, 16'h0000);
			"bi": r = mk(16'h3073, 16'h0000);
			"bu": r = mk(16'h3076, 16'h0000);
			"be": r = mk(16'h3079, 16'h0000);
			"bo": r = mk(16'h307C, 16'h0000);
			"pa": r = mk(16'h3071, 16'h0000);
			"pi": r = mk(16'h3074, 16'h0000);
			"pu": r = mk(16'h3077, 16'h0000);
			"pe": r = mk(16'h307A, 16'h0000);
			"po": r = mk(16'h307D, 16'h0000);
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic syl_t syl1(input logic [7:0] k);
		syl_t r;
		r = '0;
		case (k)
			"a": r = mk(16'h3042, 16'h0000);
			"i": r = mk(16'h3044, 16'h0000);
			"u": r = mk(16'h3046, 16'h0000);
			"e": r = mk(16'h3048, 16'h0000);
			"o": r = mk(16'h304A, 16'h0000);
			"n": r = mk(16'h3093, 16'h0000);
			default: r = '0;
		endcase
		return r;
	endfunction

	// key is compared whole against zero-padded entries: a zero byte only
	// shortens it when every byte after it is zero as well
	function automatic syl_t syl_lookup(input logic [7:0] a, input logic [7:0] b,
		input logic [7:0] c, input logic [1:0] n);
		logic [1:0] len;
		syl_t r;
		len = n;
		if (n >= 2'd2 && b == 8'd0) begin
			len = (n == 2'd3 && c != 8'd0) ? 2'd0 : 2'd1;
		end else if (n == 2'd3 && c == 8'd0) begin
			len = 2'd2;
		end
		case (len)
			2'd3: r = syl3({a, b, c});
			2'd2: r = syl2({a, b});
			2'd1: r = syl1(a);
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

/* rtl/core/rtk_queue.sv */
// rtk_queue: short operation queue between front and back
`timescale 1ns / 1ps
module rtk_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  rtk_pkg::op_t  push_data,
	output logic          full,
	input  logic          pop,
	output rtk_pkg::op_t  pop_data,
	output logic          empty
);
	localparam int DEPTH = rtk_pkg::QUEUE_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	rtk_pkg::op_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic do_push, do_pop;

	assign full = (cnt_q == CNT_W'(DEPTH));
	assign empty = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/core/rtk_front.sv */
// rtk_front: lookahead buffer, syllable decode and capacity check
`timescale 1ns / 1ps
module rtk_front #(
	parameter int LENGTH_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  rtk_pkg::in_item_t in_data,
	input  logic [15:0]       capacity,
	output logic              push,
	output rtk_pkg::op_t      push_data,
	input  logic              full
);
	localparam int CW = (LENGTH_BITS < 16) ? LENGTH_BITS : 16;

	rtk_pkg::front_state_t state_q, state_d;
	logic [2:0][7:0] pend_q;
	logic [1:0] cnt_q;
	logic [CW-1:0] wc_q;
	logic ovf_q;

	logic accept;
	logic [7:0] c0, c1, c2;
	rtk_pkg::syl_t s3, s2, s1, sel;
	logic is_tsu;
	logic [1:0] take;
	rtk_pkg::op_kind_t kind;
	logic [2:0] size;
	logic [17:0] need;
	logic fit;
	logic decode_go, status_go, advance;
	logic [2:0][7:0] pend_shift;

	assign accept = in_valid && !in_stall;

	// head decode
	always_comb begin
		c0 = rtk_pkg::fold(pend_q[0]);
		c1 = rtk_pkg::fold(pend_q[1]);
		c2 = rtk_pkg::fold(pend_q[2]);
		s3 = rtk_pkg::syl_lookup(c0, c1, c2, 2'd3);
		s2 = rtk_pkg::syl_lookup(c0, c1, c2, 2'd2);
		s1 = rtk_pkg::syl_lookup(c0, c1, c2, 2'd1);
		is_tsu = !(c0 inside {"n", "a", "i", "u", "e", "o"}) && cnt_q >= 2'd2 && c1 == c0;
		sel = '0;
		take = 2'd1;
		kind = rtk_pkg::OP_PASS;
		if (is_tsu) begin
			sel = rtk_pkg::mk(rtk_pkg::CP_SMALL_TSU, 16'h0000);
			kind = rtk_pkg::OP_KANA1;
		end else if (cnt_q == 2'd3 && s3.hit) begin
			sel = s3;
			take = 2'd3;
		end else if (cnt_q >= 2'd2 && s2.hit) begin
			sel = s2;
			take = 2'd2;
		end else if (s1.hit) begin
			sel = s1;
		end
		if (!is_tsu && sel.hit) begin
			kind = (sel.cp2 != 16'h0000) ? rtk_pkg::OP_KANA2 : rtk_pkg::OP_KANA1;
		end
		case (kind)
			rtk_pkg::OP_KANA2: size = 3'd6;
			rtk_pkg::OP_KANA1: size = 3'd3;
			default: size = 3'd1;
		endcase
		need = 18'(wc_q) + 18'(size) + 18'd1;
		fit = !ovf_q && (need <= 18'(capacity));
		case (take)
			2'd3: pend_shift = '0;
			2'd2: pend_shift = {8'd0, 8'd0, pend_q[2]};
			default: pend_shift = {8'd0, pend_q[2], pend_q[1]};
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rtk_pkg::FS_IDLE: begin
				if (accept && in_data.end_of_string) begin
					state_d = rtk_pkg::FS_FLUSH;
				end else if (accept && in_data.char_valid && cnt_q == 2'd2) begin
					state_d = rtk_pkg::FS_STEP;
				end
			end
			rtk_pkg::FS_STEP: begin
				if (advance) begin
					state_d = rtk_pkg::FS_IDLE;
				end
			end
			rtk_pkg::FS_FLUSH: begin
				if (status_go && advance) begin
					state_d = rtk_pkg::FS_IDLE;
				end
			end
			default: state_d = rtk_pkg::FS_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_stall = (state_q != rtk_pkg::FS_IDLE);
		decode_go = (state_q == rtk_pkg::FS_STEP)
			|| (state_q == rtk_pkg::FS_FLUSH && cnt_q != 2'd0);
		status_go = (state_q == rtk_pkg::FS_FLUSH) && cnt_q == 2'd0;
		push = ((decode_go && fit) || status_go) && !full;
		advance = decode_go ? (!fit || !full) : (status_go && !full);
		push_data.kind = status_go ? rtk_pkg::OP_STATUS : kind;
		push_data.cp1 = sel.cp1;
		push_data.cp2 = sel.cp2;
		push_data.data = pend_q[0];
		push_data.ovf = ovf_q || capacity == 16'd0;
		push_data.total = 16'(wc_q);
		push_data.last = (state_q == rtk_pkg::FS_STEP) || status_go;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rtk_pkg::FS_IDLE;
			pend_q <= '0;
			cnt_q <= '0;
			wc_q <= '0;
			ovf_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept && in_data.char_valid) begin
				pend_q[cnt_q] <= in_data.in_char;
				cnt_q <= cnt_q + 2'd1;
			end
			if (advance && decode_go) begin
				pend_q <= pend_shift;
				cnt_q <= cnt_q - take;
				if (fit) begin
					wc_q <= wc_q + CW'(size);
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (advance && status_go) begin
				pend_q <= '0;
				cnt_q <= '0;
				wc_q <= '0;
				ovf_q <= 1'b0;
			end
		end
	end

`ifndef ASSERT_OFF
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("op pushed into full queue");
	a_idle_room: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == rtk_pkg::FS_IDLE |-> cnt_q != 2'd3) else $error("full buffer while idle");
	a_status_clears: assert property (@(posedge clk) disable iff (!arst_n)
		push && push_data.kind == rtk_pkg::OP_STATUS |=> wc_q == '0 && !ovf_q)
		else $error("string state not cleared after status");
`endif

endmodule

/* rtl/core/rtk_back.sv */
// rtk_back: expands queued operations into result beats
`timescale 1ns / 1ps
module rtk_back (
	input  logic               clk,
	input  logic               arst_n,
	input  rtk_pkg::op_t       op,
	input  logic               empty,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output rtk_pkg::out_item_t out_data
);
	logic [2:0] idx_q;
	logic out_valid_q;
	rtk_pkg::out_item_t out_data_q;
	logic load, final_beat;
	rtk_pkg::out_item_t beat;

	assign load = !empty && (!out_valid_q || !out_stall);
	assign pop = load && final_beat;
	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	always_comb begin
		beat = '0;
		final_beat = 1'b1;
		unique case (op.kind)
			rtk_pkg::OP_STATUS: begin
				beat.string_done = 1'b1;
				beat.overflow = op.ovf;
				beat.total_length = op.total;
			end
			rtk_pkg::OP_PASS: begin
				beat.byte_valid = 1'b1;
				beat.out_byte = op.data;
			end
			rtk_pkg::OP_KANA1, rtk_pkg::OP_KANA2: begin
				beat.byte_valid = 1'b1;
				final_beat = (op.kind == rtk_pkg::OP_KANA1) ? (idx_q == 3'd2) : (idx_q == 3'd5);
				case (idx_q)
					3'd1: beat.out_byte = {2'b10, op.cp1[11:6]};
					3'd2: beat.out_byte = {2'b10, op.cp1[5:0]};
					3'd4: beat.out_byte = {2'b10, op.cp2[11:6]};
					3'd5: beat.out_byte = {2'b10, op.cp2[5:0]};
					default: beat.out_byte = rtk_pkg::UTF8_LEAD;
				endcase
			end
			default: beat = '0;
		endcase
		beat.run_last = final_beat && op.last;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_data_q <= beat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q <= final_beat ? 3'd0 : idx_q + 3'd1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* rtl/core/romaji_to_kana_transliterator_top.sv */
// romaji_to_kana_transliterator_top: top level of the romaji to hiragana transliterator
//
// channel  dir  handshake             payload
// in       in   in_valid / in_stall   rtk_pkg::in_item_t  (source byte, end marker)
// out      out  out_valid / out_stall rtk_pkg::out_item_t (utf-8 byte or status)
// cfg      in   cfg_valid / cfg_ready cfg_data, output capacity in bytes
//
// the front takes one item per visit to idle; a byte that fills the lookahead is followed by
// a head decode, an end marker by one decode per buffered unit and then a status op
// the back gives one beat per cycle unless empty or stalled: three per kana, six per digraph,
// one per pass-through byte or status, so sustained rate is set by the byte count at the output register
// reset clears buffer, counters, queue and sets capacity to 65535
// the input is stalled whenever the front is not idle: during a head decode, during a
// flush, and longer while a decode waits on the full four-entry queue; a stalled output
// holds the queue
`timescale 1ns / 1ps
module romaji_to_kana_transliterator_top #(
	parameter int LENGTH_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  rtk_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output rtk_pkg::out_item_t out_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [15:0]        cfg_data
);
	// capacity register; the user must write it only while the block is quiet, the block does not enforce it
	logic [15:0] capacity_q;

	// front to queue
	logic push, full;
	rtk_pkg::op_t push_data;

	// queue to back
	logic pop, empty;
	rtk_pkg::op_t pop_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= 16'hFFFF;
		end else if (cfg_valid && cfg_ready) begin
			capacity_q <= cfg_data;
		end
	end

	// decode and capacity check
	rtk_front #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.capacity(capacity_q),
		.push(push),
		.push_data(push_data),
		.full(full)
	);

	// decouples decode from byte output
	rtk_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(push_data),
		.full(full),
		.pop(pop),
		.pop_data(pop_data),
		.empty(empty)
	);

	// one beat per cycle out of the registered output, unless empty or stalled
	rtk_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.op(pop_data),
		.empty(empty),
		.pop(pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

endmodule

/* dv/romaji_to_kana_transliterator_top_tb.sv */
// romaji_to_kana_transliterator_top_tb: self-checking testbench for the romaji to kana top level
`timescale 1ns / 1ps
module romaji_to_kana_transliterator_top_tb;

	localparam logic [15:0] TSU_SMALL = 16'h3063;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct {
		string       key;
		logic [15:0] a;
		logic [15:0] b;
	} syl_entry_t;

	// kana predictor and store of expected utf-8 beats
	class kana_scoreboard;
		syl_entry_t tab[] = '{
			'{"kya",16'h304D,16'h3083},'{"kyu",16'h304D,16'h3085},'{"kyo",16'h304D,16'h3087},
			'{"sha",16'h3057,16'h3083},'{"shu",16'h3057,16'h3085},'{"sho",16'h3057,16'h3087},
			'{"sya",16'h3057,16'h3083},'{"syu",16'h3057,16'h3085},
			'{"cha",16'h3061,16'h3083},'{"chu",16'h3061,16'h3085},'{"cho",16'h3061,16'h3087},
			'{"tya",16'h3061,16'h3083},'{"tyu",16'h3061,16'h3085},
			'{"nya",16'h306B,16'h3083},'{"nyu",16'h306B,16'h3085},'{"nyo",16'h306B,16'h3087},
			'{"hya",16'h3072,16'h3083},'{"hyu",16'h3072,16'h3085},'{"hyo",16'h3072,16'h3087},
			'{"mya",16'h307F,16'h3083},'{"myu",16'h307F,16'h3085},'{"myo",16'h307F,16'h3087},
			'{"rya",16'h308A,16'h3083},'{"ryu",16'h308A,16'h3085},'{"ryo",16'h308A,16'h3087},
			'{"gya",16'h304E,16'h3083},'{"gyu",16'h304E,16'h3085},'{"gyo",16'h304E,16'h3087},
			'{"ja",16'h3058,16'h3083},'{"ju",16'h3058,16'h3085},'{"jo",16'h3058,16'h3087},
			'{"jya",16'h3058,16'h3083},'{"jyu",16'h3058,16'h3085},'{"jyo",16'h3058,16'h3087},
			'{"zya",16'h3058,16'h3083},'{"zyu",16'h3058,16'h3085},
			'{"bya",16'h3073,16'h3083},'{"byu",16'h3073,16'h3085},'{"byo",16'h3073,16'h3087},
			'{"pya",16'h3074,16'h3083},'{"pyu",16'h3074,16'h3085},'{"pyo",16'h3074,16'h3087},
			'{"shi",16'h3057,16'h0},'{"chi",16'h3061,16'h0},'{"tsu",16'h3064,16'h0},
			'{"ka",16'h304B,16'h0},'{"ki",16'h304D,16'h0},'{"ku",16'h304F,16'h0},
			'{"ke",16'h3051,16'h0},'{"ko",16'h3053,16'h0},
			'{"sa",16'h3055,16'h0},'{"si",16'h3057,16'h0},'{"su",16'h3059,16'h0},
			'{"se",16'h305B,16'h0},'{"so",16'h305D,16'h0},
			'{"ta",16'h305F,16'h0},'{"ti",16'h3061,16'h0},'{"tu",16'h3064,16'h0},
			'{"te",16'h3066,16'h0},'{"to",16'h3068,16'h0},
			'{"na",16'h306A,16'h0},'{"ni",16'h306B,16'h0},'{"nu",16'h306C,16'h0},
			'{"ne",16'h306D,16'h0},'{"no",16'h306E,16'h0},
			'{"ha",16'h306F,16'h0},'{"hi",16'h3072,16'h0},'{"fu",16'h3075,16'h0},
			'{"hu",16'h3075,16'h0},'{"he",16'h3078,16'h0},'{"ho",16'h307B,16'h0},
			'{"ma",16'h307E,16'h0},'{"mi",16'h307F,16'h0},'{"mu",16'h3080,16'h0},
			'{"me",16'h3081,16'h0},'{"mo",16'h3082,16'h0},
			'{"ya",16'h3084,16'h0},'{"yu",16'h3086,16'h0},'{"yo",16'h3088,16'h0},
			'{"ra",16'h3089,16'h0},'{"ri",16'h308A,16'h0},'{"ru",16'h308B,16'h0},
			'{"re",16'h308C,16'h0},'{"ro",16'h308D,16'h0},
			'{"wa",16'h308F,16'h0},'{"wo",16'h3092,16'h0},
			'{"ga",16'h304C,16'h0},'{"gi",16'h304E,16'h0},'{"gu",16'h3050,16'h0},
			'{"ge",16'h3052,16'h0},'{"go",16'h3054,16'h0},
			'{"za",16'h3056,16'h0},'{"zi",16'h3058,16'h0},'{"ji",16'h3058,16'h0},
			'{"zu",16'h305A,16'h0},'{"ze",16'h305C,16'h0},'{"zo",16'h305E,16'h0},
			'{"da",16'h3060,16'h0},'{"di",16'h3062,16'h0},'{"du",16'h3065,16'h0},
			'{"de",16'h3067,16'h0},'{"do",16'h3069,16'h0},
			'{"ba",16'h3070,16'h0},'{"bi",16'h3073,16'h0},'{"bu",16'h3076,16'h0},
			'{"be",16'h3079,16'h0},'{"bo",16'h307C,16'h0},
			'{"pa",16'h3071,16'h0},'{"pi",16'h3074,16'h0},'{"pu",16'h3077,16'h0},
			'{"pe",16'h307A,16'h0},'{"po",16'h307D,16'h0},
			'{"a",16'h3042,16'h0},'{"i",16'h3044,16'h0},'{"u",16'h3046,16'h0},
			'{"e",16'h3048,16'h0},'{"o",16'h304A,16'h0},'{"n",16'h3093,16'h0}
		};
		rtk_pkg::out_item_t kana_q[$];
		logic [7:0]  look[3] = '{8'h0, 8'h0, 8'h0};
		int          look_n = 0;
		logic [15:0] written = 16'h0;
		bit          ovf_seen = 1'b0;
		logic [15:0] capacity = 16'hFFFF;
		int          errors = 0;

		task report(string msg);
			$display("ERROR: %s", msg);
			errors++;
		endtask

		function logic [7:0] lower(logic [7:0] c);
			return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
		endfunction

		function logic [23:0] pad(string s);
			logic [23:0] r;
			r = '0;
			for (int i = 0; i < s.len(); i++) r[23 - 8 * i -: 8] = s[i];
			return r;
		endfunction

		function bit fits(int len);
			if (ovf_seen) return 1'b0;
			if (int'(written) + len + 1 > int'(capacity)) begin
				ovf_seen = 1'b1;
				return 1'b0;
			end
			return 1'b1;
		endfunction

		function void emit(logic [7:0] b);
			rtk_pkg::out_item_t r;
			r = '0;
			r.out_byte = b;
			r.byte_valid = 1'b1;
			kana_q.push_back(r);
		endfunction

		function void emit_cp(logic [15:0] cp);
			emit(8'hE3);
			emit({2'b10, cp[11:6]});
			emit({2'b10, cp[5:0]});
		endfunction

		function void kana(logic [15:0] a, logic [15:0] b);
			int len;
			len = (b != 0) ? 6 : 3;
			if (!fits(len)) return;
			emit_cp(a);
			if (b != 0) emit_cp(b);
			written = written + 16'(len);
		endfunction

		function void shift_out(int n);
			if (n > look_n) n = look_n;
			for (int i = 0; i < 3; i++) look[i] = (i + n < 3) ? look[i + n] : 8'h0;
			look_n -= n;
		endfunction

		function void decode_head();
			logic [7:0]  c0;
			logic [23:0] key;
			if (look_n == 0) return;
			c0 = lower(look[0]);
			// doubled consonant (any pair of equal bytes other than n or a vowel) gives small tsu
			if (!(c0 inside {"n", "a", "i", "u", "e", "o"}) && look_n >= 2 &&
					lower(look[1]) == c0) begin
				kana(TSU_SMALL, 16'h0);
				shift_out(1);
				return;
			end
			for (int take = (look_n > 3 ? 3 : look_n); take >= 1; take--) begin
				key = '0;
				for (int i = 0; i < take; i++) key[23 - 8 * i -: 8] = lower(look[i]);
				foreach (tab[t]) begin
					if (pad(tab[t].key) == key) begin
						kana(tab[t].a, tab[t].b);
						shift_out(take);
						return;
					end
				end
			end
			if (fits(1)) begin
				emit(look[0]);
				written = written + 16'd1;
			end
			shift_out(1);
		endfunction

		function void note_input(rtk_pkg::in_item_t it);
			int n0;
			rtk_pkg::out_item_t r;
			n0 = kana_q.size();
			if (it.char_valid) begin
				while (look_n >= 3) decode_head();
				look[look_n] = it.in_char;
				look_n++;
				if (!it.end_of_string && look_n == 3) decode_head();
			end
			if (it.end_of_string) begin
				while (look_n > 0) decode_head();
				if (capacity == 0) ovf_seen = 1'b1;
				r = '0;
				r.string_done = 1'b1;
				r.overflow = ovf_seen;
				r.total_length = written;
				kana_q.push_back(r);
				look = '{8'h0, 8'h0, 8'h0};
				look_n = 0;
				written = 16'h0;
				ovf_seen = 1'b0;
			end
			if (kana_q.size() > n0) kana_q[$].run_last = 1'b1;
		endfunction

		task cmp(string name, logic [15:0] got, logic [15:0] want);
			if (got !== want) report($sformatf("%s got %h want %h", name, got, want));
		endtask

		task check(rtk_pkg::out_item_t g);
			rtk_pkg::out_item_t e;
			if (kana_q.size() == 0) begin
				report($sformatf("unexpected beat %h", g));
				return;
			end
			e = kana_q.pop_front();
			cmp("out_byte", 16'(g.out_byte), 16'(e.out_byte));
			cmp("byte_valid", 16'(g.byte_valid), 16'(e.byte_valid));
			cmp("string_done", 16'(g.string_done), 16'(e.string_done));
			cmp("overflow", 16'(g.overflow), 16'(e.overflow));
			cmp("total_length", g.total_length, e.total_length);
			cmp("run_last", 16'(g.run_last), 16'(e.run_last));
		endtask
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	rtk_pkg::in_item_t  in_data = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	rtk_pkg::out_item_t out_data;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [15:0]        cfg_data = 16'h0;

	kana_scoreboard sb = new;
	int             snd_pct = 34;
	int             rcv_pct = 62;
	int             cycles = 0;
	int             items_sent = 0;
	logic [7:0]     src_bytes[$];

	romaji_to_kana_transliterator_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #4 clk = ~clk;

	// cycle guard against a hung handshake
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// output side: sample the beat with pre-edge values, then pick the next stall
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) sb.check(out_data);
		out_stall <= ($urandom_range(99) < rcv_pct);
	end

	// one input beat, with random idle cycles ahead of it
	task automatic send_item(rtk_pkg::in_item_t it);
		while ($urandom_range(99) < snd_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (in_stall);
		sb.note_input(it);
		items_sent++;
	endtask

	// sends src_bytes as one string; bare closes it with an end marker carrying no byte
	task automatic send_string(bit bare);
		rtk_pkg::in_item_t it;
		for (int i = 0; i < src_bytes.size(); i++) begin
			if ($urandom_range(99) < 8) begin
				// idle item: no byte, no end, ignored by the block
				it.in_char = 8'($urandom);
				it.char_valid = 1'b0;
				it.end_of_string = 1'b0;
				send_item(it);
			end
			it.in_char = src_bytes[i];
			it.char_valid = 1'b1;
			it.end_of_string = (i == src_bytes.size() - 1) && !bare;
			send_item(it);
		end
		if (bare || src_bytes.size() == 0) begin
			it.in_char = 8'($urandom);
			it.char_valid = 1'b0;
			it.end_of_string = 1'b1;
			send_item(it);
		end
	endtask

	task automatic send_text(string s, bit bare);
		src_bytes.delete();
		for (int i = 0; i < s.len(); i++) src_bytes.push_back(s[i]);
		send_string(bare);
	endtask

	// hold off until every expected beat is out and the buffer has drained
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.kana_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_capacity(logic [15:0] v);
		settle();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.capacity = v;
	endtask

	function automatic logic [7:0] mixed_case(logic [7:0] c);
		return (c >= "a" && c <= "z" && $urandom_range(1)) ? c - 8'd32 : c;
	endfunction

	// mostly well-formed romaji with random case, some doubled consonants and noise
	task automatic make_string();
		int    units;
		int    pick;
		bit    noise;
		string k;
		src_bytes.delete();
		units = $urandom_range(0, 7);
		noise = ($urandom_range(99) < 15);
		for (int u = 0; u < units; u++) begin
			pick = $urandom_range(99);
			if (noise || pick >= 88) begin
				src_bytes.push_back(8'($urandom));
			end else if (pick < 65) begin
				k = sb.tab[$urandom_range(0, sb.tab.size() - 1)].key;
				for (int i = 0; i < k.len(); i++) src_bytes.push_back(mixed_case(k[i]));
			end else if (pick < 80) begin
				do k = sb.tab[$urandom_range(0, sb.tab.size() - 1)].key;
				while (k[0] inside {"n", "a", "i", "u", "e", "o"});
				src_bytes.push_back(mixed_case(k[0]));
				for (int i = 0; i < k.len(); i++) src_bytes.push_back(mixed_case(k[i]));
			end else begin
				src_bytes.push_back(mixed_case("n"));
			end
		end
	endtask

	function automatic logic [15:0] pick_capacity();
		case ($urandom_range(0, 5))
			0: return 16'd0;
			1: return 16'd1;
			2: return 16'hFFFF;
			3: return 16'($urandom_range(2, 12));
			4: return 16'($urandom_range(13, 60));
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	initial begin
		int strings;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: digraph, small tsu, n handling, three-byte keys, pass-through
		write_capacity(16'hFFFF);
		send_text("kyA", 1'b0);
		send_text("KKo", 1'b0);
		send_text("nna", 1'b1);
		send_text("Tsu", 1'b0);
		send_text("SHI", 1'b1);
		src_bytes = '{8'h00, 8'hFF, "%", "%"};
		send_string(1'b0);
		src_bytes.delete();
		send_string(1'b1);
		// zero capacity overflows at once, tight capacity cuts the second kana, a digraph just fits
		write_capacity(16'd0);
		send_text("a", 1'b0);
		write_capacity(16'd4);
		send_text("kaki", 1'b0);
		write_capacity(16'd7);
		send_text("kya", 1'b1);

		// random phases: receiver-heavy stalling, sender-heavy idling, then full rate
		for (int phase = 0; phase < 3; phase++) begin
			snd_pct = (phase == 0) ? 34 : (phase == 1) ? 62 : 0;
			rcv_pct = (phase == 0) ? 62 : (phase == 1) ? 34 : 0;
			strings = 0;
			while (items_sent < 70 * (phase + 1) + 20) begin
				if (strings % 4 == 0) write_capacity(pick_capacity());
				make_string();
				send_string($urandom_range(99) < 30);
				strings++;
			end
		end
		in_valid <= 1'b0;

		while (sb.kana_q.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (sb.errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
